// ===== rtl/core/bsam_pkg.sv =====
// shared types and constants for the sorted-table search block
package bsam_pkg;

  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int QDEPTH = 2;

  // item kinds carried through the queue
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // register addresses on the configuration port
  localparam logic [1:0] ADDR_TABLE_LENGTH = 2'd0;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } q_entry_t;

endpackage

// ===== rtl/core/bsam_ram.sv =====
// generic single-port-write, registered-read RAM
module bsam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bsam_queue.sv =====
// short queue between the front and the back
module bsam_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bsam_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output bsam_pkg::q_entry_t pop_entry,
  output logic               empty
);
  import bsam_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_entry_t        slot_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(QDEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/bsam_front.sv =====
// input stage: takes items, classifies them and feeds the queue
module bsam_front #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_opcode,
  input  logic [bsam_pkg::IDX_W-1:0] in_load_index,
  input  logic [bsam_pkg::DATA_W-1:0] in_load_value,
  input  logic [bsam_pkg::DATA_W-1:0] in_search_key,
  output logic                       q_push,
  output bsam_pkg::q_entry_t         q_entry,
  input  logic                       q_full
);
  import bsam_pkg::*;

  logic     stage_v_r, stage_v_nxt;
  q_entry_t stage_r;
  q_entry_t classed;
  logic     keep;
  logic     accept;

  // classify: loads carry the value, searches the key; loads off the table are dropped
  always_comb begin
    classed.kind = (in_opcode == KIND_SEARCH) ? KIND_SEARCH : KIND_LOAD;
    classed.idx  = in_load_index;
    classed.data = (in_opcode == KIND_SEARCH) ? in_search_key : in_load_value;
    keep = (in_opcode == KIND_SEARCH) ||
           ({1'b0, in_load_index} < (IDX_W + 1)'(TABLE_DEPTH));
  end

  assign in_tready = !stage_v_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = stage_v_r;
  assign q_entry   = stage_r;

  // stage valid
  always_comb begin
    stage_v_nxt = stage_v_r;
    if (accept) begin
      stage_v_nxt = keep;
    end else if (stage_v_r && !q_full) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= classed;
    end
  end

endmodule

// ===== rtl/core/bsam_back.sv =====
// search engine: table memory, binary search, duplicate scan, result register
module bsam_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bsam_pkg::LEN_W-1:0]  table_length,
  input  logic                        q_empty,
  input  bsam_pkg::q_entry_t          q_entry,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic                        out_found,
  output logic [bsam_pkg::IDX_W-1:0]  out_match_index,
  output logic                        out_tlast
);
  import bsam_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PROBE = 4'd1;
  localparam logic [3:0] ST_PCMP  = 4'd2;
  localparam logic [3:0] ST_UP    = 4'd3;
  localparam logic [3:0] ST_UCMP  = 4'd4;
  localparam logic [3:0] ST_DN    = 4'd5;
  localparam logic [3:0] ST_DCMP  = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_MISS  = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic signed [7:0]       low_r, low_nxt;
  logic signed [7:0]       high_r, high_nxt;
  logic signed [7:0]       mid_r, mid_nxt;
  logic signed [7:0]       i_r, i_nxt;
  logic signed [7:0]       hit_r, hit_nxt;
  logic [LEN_W-1:0]        n_r, n_nxt;
  logic [DATA_W-1:0]       key_r, key_nxt;
  logic [IDX_W-1:0]        pend_r, pend_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [DATA_W-1:0]       ram_rdata;

  logic [LEN_W-1:0]        n_lim;
  logic signed [8:0]       mid_sum;
  logic signed [7:0]       mid_w;
  logic                    push_ok, push;
  logic                    push_found, push_last;
  logic [IDX_W-1:0]        push_idx;
  logic                    key_eq, key_lt;

  bsam_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_entry.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // searched length is clipped to the table size
  assign n_lim = (table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : table_length;

  // midpoint of a non-empty range, both bounds non-negative there
  assign mid_sum = {low_r[7], low_r} + {high_r[7], high_r};
  assign mid_w   = mid_sum[8:1];

  assign key_eq  = (ram_rdata == key_r);
  assign key_lt  = ($signed(key_r) < $signed(ram_rdata));
  assign push_ok = !out_valid_r || out_tready;
  assign ram_waddr = q_entry.idx[AW-1:0];

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    mid_nxt    = mid_r;
    i_nxt      = i_r;
    hit_nxt    = hit_r;
    n_nxt      = n_r;
    key_nxt    = key_r;
    pend_nxt   = pend_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = mid_w[AW-1:0];
    push       = 1'b0;
    push_found = 1'b1;
    push_idx   = pend_r;
    push_last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_entry.kind == KIND_LOAD) begin
            ram_we = 1'b1;
          end else begin
            key_nxt   = q_entry.data;
            n_nxt     = n_lim;
            low_nxt   = '0;
            high_nxt  = $signed({1'b0, n_lim}) - 8'sd1;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (low_r > high_r) begin
          state_nxt = ST_MISS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = mid_w[AW-1:0];
          mid_nxt   = mid_w;
          state_nxt = ST_PCMP;
        end
      end
      ST_PCMP: begin
        if (key_eq) begin
          pend_nxt  = mid_r[IDX_W-1:0];
          hit_nxt   = mid_r;
          i_nxt     = mid_r + 8'sd1;
          state_nxt = ST_UP;
        end else if (key_lt) begin
          high_nxt  = mid_r - 8'sd1;
          state_nxt = ST_PROBE;
        end else begin
          low_nxt   = mid_r + 8'sd1;
          state_nxt = ST_PROBE;
        end
      end
      // upward scan over equal neighbours
      ST_UP: begin
        if (i_r < $signed({1'b0, n_r})) begin
          ram_re    = 1'b1;
          ram_raddr = i_r[AW-1:0];
          state_nxt = ST_UCMP;
        end else begin
          i_nxt     = hit_r - 8'sd1;
          state_nxt = ST_DN;
        end
      end
      ST_UCMP: begin
        if (!key_eq) begin
          i_nxt     = hit_r - 8'sd1;
          state_nxt = ST_DN;
        end else if (push_ok) begin
          push      = 1'b1;
          pend_nxt  = i_r[IDX_W-1:0];
          i_nxt     = i_r + 8'sd1;
          state_nxt = ST_UP;
        end
      end
      // downward scan over equal neighbours
      ST_DN: begin
        if (i_r >= 8'sd0) begin
          ram_re    = 1'b1;
          ram_raddr = i_r[AW-1:0];
          state_nxt = ST_DCMP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DCMP: begin
        if (!key_eq) begin
          state_nxt = ST_FIN;
        end else if (push_ok) begin
          push      = 1'b1;
          pend_nxt  = i_r[IDX_W-1:0];
          i_nxt     = i_r - 8'sd1;
          state_nxt = ST_DN;
        end
      end
      ST_FIN: begin
        if (push_ok) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (push_ok) begin
          push       = 1'b1;
          push_found = 1'b0;
          push_idx   = '0;
          push_last  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = push_found;
      out_idx_nxt   = push_idx;
      out_last_nxt  = push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r       <= low_nxt;
    high_r      <= high_nxt;
    mid_r       <= mid_nxt;
    i_r         <= i_nxt;
    hit_r       <= hit_nxt;
    n_r         <= n_nxt;
    key_r       <= key_nxt;
    pend_r      <= pend_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid      = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_idx_r;
  assign out_tlast       = out_last_r;

endmodule

// ===== rtl/core/binary_search_all_matches.sv =====
// top level of the sorted-table search block
//
//  channel | direction | handshake              | payload
//  in_     | sink      | in_tvalid / in_tready  | tuser: opcode; tdata: index, value, key
//  out_    | source    | out_tvalid / out_tready| tuser: found; tdata: match_index; tlast
//  cfg_    | apb slave | psel, penable, pready  | table_length at address 0
//
// a load is written into the table ram as it leaves the queue; a search runs a binary
// search with a read state and a compare state for each probe and each equal neighbour
// scanned, as the table ram has a registered read.
// reset clears control state only; table entries are undefined until loaded.
// either side may stall: a two-entry queue and the result register decouple them.
module binary_search_all_matches #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // load_index[5:0], load_value[37:6], search_key[69:38]
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // match_index[5:0]
  output logic [0:0]  out_tuser,  // found[0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bsam_pkg::*;

  logic [LEN_W-1:0] length_r, length_nxt;
  logic             cfg_wr;
  logic             q_push, q_full, q_pop, q_empty;
  q_entry_t         q_in, q_out;
  logic [IDX_W-1:0] match_index;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_TABLE_LENGTH) ? {{(32 - LEN_W){1'b0}}, length_r} : '0;

  always_comb begin
    length_nxt = length_r;
    if (cfg_wr && (cfg_paddr == ADDR_TABLE_LENGTH)) begin
      length_nxt = cfg_pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
    end else begin
      length_r <= length_nxt;
    end
  end

  bsam_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_opcode     (in_tuser[0]),
    .in_load_index (in_tdata[5:0]),
    .in_load_value (in_tdata[37:6]),
    .in_search_key (in_tdata[69:38]),
    .q_push        (q_push),
    .q_entry       (q_in),
    .q_full        (q_full)
  );

  bsam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .empty      (q_empty)
  );

  bsam_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .table_length    (length_r),
    .q_empty         (q_empty),
    .q_entry         (q_out),
    .q_pop           (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_found       (out_tuser[0]),
    .out_match_index (match_index),
    .out_tlast       (out_tlast)
  );

  assign out_tdata = {2'b00, match_index};

endmodule

// ===== rtl/core/bsam_checker.sv =====
// port-level checks on the result channel, bound to the top level
module bsam_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  // a miss is always a single, final item
  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("not-found item without last");

  // a miss carries index zero
  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 8'd0))
    else $error("not-found item with nonzero index");

  // a stalled item keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("result changed while stalled");

  // padding bits of the index word stay clear
  a_pad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] == 2'b00))
    else $error("result padding bits set");

endmodule

bind binary_search_all_matches bsam_checker u_bsam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
